FILE: src/biquad_cascade_equalizer_macros.svh
// assertion macros used by the equalizer sequencer
`ifndef BIQUAD_CASCADE_EQUALIZER_MACROS_SVH
`define BIQUAD_CASCADE_EQUALIZER_MACROS_SVH

// same-cycle implication, disabled during reset
`define BQEQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define BQEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/bqeq_pkg.sv
// shared types, constants and the config and command structs of the biquad cascade equalizer
package bqeq_pkg;

  localparam int DEFAULT_NUM_SECTIONS = 8;
  localparam int SEC_MAX_W            = 5;

  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 26;
  localparam int DATA_W     = 32;
  localparam int PROD_W     = 58;
  localparam int ACC_W      = 60;
  localparam int GAIN_W     = 24;
  localparam int GPROD_W    = 57;
  localparam int WIDE_W     = 37;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int COEF_SEC_W = 3;
  localparam int COEF_SEL_W = 3;
  localparam int TAP_W      = 3;
  localparam int ACT_W      = 4;
  localparam int ENABLE_W   = 8;

  localparam int TAPS         = 5;
  localparam int HIST_PER_SEC = 8;
  localparam int HIST_PER_CH  = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_SECTIONS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECTION_ENABLE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_FIRST      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_GAIN        = 3'd4;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_COEF   = 1'b1;

  localparam logic [TAP_W-1:0] TAP_B0 = 3'd0;
  localparam logic [TAP_W-1:0] TAP_A1 = 3'd3;
  localparam logic [TAP_W-1:0] TAP_A2 = 3'd4;

  localparam logic              STEREO_RESET = 1'b1;
  localparam logic [GAIN_W-1:0] GAIN_RESET   = 24'd1048576;

  typedef enum logic [1:0] {
    HSLOT_X1 = 2'd0,
    HSLOT_X2 = 2'd1,
    HSLOT_Y1 = 2'd2,
    HSLOT_Y2 = 2'd3
  } hist_slot_t;

  typedef struct packed {
    logic [ACT_W-1:0]    active_sections;
    logic [ENABLE_W-1:0] section_enable;
    logic                skip_first_section;
    logic                stereo_mode;
    logic [GAIN_W-1:0]   out_gain;
  } cfg_t;

  typedef struct packed {
    logic                 capture;
    logic                 coef_wr;
    logic                 mac_issue;
    logic [TAP_W-1:0]     tap;
    logic [SEC_MAX_W-1:0] sec;
    logic                 ch;
    logic                 hist_wr;
    hist_slot_t           hist_slot;
    logic                 gain_mul;
    logic                 gain_rnd;
    logic                 mono_sat;
    logic                 publish;
  } cmd_t;

endpackage

FILE: src/bqeq_regs.sv
// configuration register bank of the equalizer
module bqeq_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bqeq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bqeq_pkg::CFG_DATA_W-1:0]     cfg_data,
  output bqeq_pkg::cfg_t                      cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_sections    <= '0;
      cfg.section_enable     <= '0;
      cfg.skip_first_section <= 1'b0;
      cfg.stereo_mode        <= bqeq_pkg::STEREO_RESET;
      cfg.out_gain           <= bqeq_pkg::GAIN_RESET;
    end else if (cfg_valid) begin
      // indexes past the list are dropped
      unique case (cfg_index)
        bqeq_pkg::REG_ACTIVE_SECTIONS:
          cfg.active_sections <= cfg_data[bqeq_pkg::ACT_W-1:0];
        bqeq_pkg::REG_SECTION_ENABLE:
          cfg.section_enable <= cfg_data[bqeq_pkg::ENABLE_W-1:0];
        bqeq_pkg::REG_SKIP_FIRST:
          cfg.skip_first_section <= cfg_data[0];
        bqeq_pkg::REG_STEREO_MODE:
          cfg.stereo_mode <= cfg_data[0];
        bqeq_pkg::REG_OUT_GAIN:
          cfg.out_gain <= cfg_data[bqeq_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: src/bqeq_ctrl.sv
// sequencer: walks sections and channels and drives the datapath commands
`include "biquad_cascade_equalizer_macros.svh"

module bqeq_ctrl #(
  parameter int NUM_SECTIONS = bqeq_pkg::DEFAULT_NUM_SECTIONS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           func,
  output logic           out_valid,
  input  logic           out_ready,
  input  bqeq_pkg::cfg_t cfg,
  output bqeq_pkg::cmd_t cmd
);

  localparam int SEC_CNT_W = $clog2(NUM_SECTIONS + 1);
  localparam int SEC_W     = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
  localparam int CMP_W     = (SEC_CNT_W > bqeq_pkg::ACT_W) ? SEC_CNT_W : bqeq_pkg::ACT_W;

  localparam logic [2:0] STEP_WR_X2 = 3'd2;
  localparam logic [2:0] STEP_WR_X1 = 3'd3;
  localparam logic [2:0] STEP_WR_Y2 = 3'd4;
  localparam logic [2:0] STEP_LAST  = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COEF,
    ST_SCAN,
    ST_PASS,
    ST_GMUL,
    ST_GRND,
    ST_MSAT,
    ST_PUB
  } state_t;

  state_t               state;
  logic [SEC_CNT_W-1:0] i_cnt;
  logic [2:0]           step;
  logic                 ch;

  logic                    in_fire;
  logic                    out_free;
  logic [CMP_W-1:0]        act_ext;
  logic [SEC_CNT_W-1:0]    n_eff;
  logic [NUM_SECTIONS-1:0] en_vec;
  logic                    sec_on;
  logic                    pass_done;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // sections walked, clamped to the cascade length
  always_comb begin
    act_ext = CMP_W'(cfg.active_sections);
    if (act_ext > CMP_W'(NUM_SECTIONS)) begin
      n_eff = SEC_CNT_W'(NUM_SECTIONS);
    end else begin
      n_eff = SEC_CNT_W'(act_ext);
    end
  end

  // filtering sections: enable bit present and set, first one maybe forced off
  always_comb begin
    for (int j = 0; j < NUM_SECTIONS; j++) begin
      en_vec[j] = (j < bqeq_pkg::ENABLE_W) ? cfg.section_enable[j % bqeq_pkg::ENABLE_W] : 1'b0;
    end
    en_vec[0] = en_vec[0] && !cfg.skip_first_section;
  end

  assign sec_on    = en_vec[i_cnt[SEC_W-1:0]];
  assign pass_done = (step == STEP_LAST) && !(!ch && cfg.stereo_mode);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      i_cnt     <= '0;
      step      <= '0;
      ch        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            state <= (func == bqeq_pkg::FUNC_COEF) ? ST_COEF : ST_SCAN;
            i_cnt <= '0;
            step  <= '0;
            ch    <= 1'b0;
          end
        end
        ST_COEF: begin
          state <= ST_IDLE;
        end
        ST_SCAN: begin
          if (i_cnt >= n_eff) begin
            state <= cfg.stereo_mode ? ST_GMUL : ST_MSAT;
            ch    <= 1'b0;
          end else if (sec_on) begin
            state <= ST_PASS;
            step  <= '0;
            ch    <= 1'b0;
          end else begin
            i_cnt <= i_cnt + 1'b1;
          end
        end
        ST_PASS: begin
          step <= step + 1'b1;
          if (step == STEP_LAST) begin
            if (pass_done) begin
              state <= ST_SCAN;
              ch    <= 1'b0;
              i_cnt <= i_cnt + 1'b1;
            end else begin
              ch <= 1'b1;
            end
          end
        end
        ST_GMUL: begin
          state <= ST_GRND;
        end
        ST_GRND: begin
          if (ch) begin
            state <= ST_PUB;
          end else begin
            state <= ST_GMUL;
            ch    <= 1'b1;
          end
        end
        ST_MSAT: begin
          state <= ST_PUB;
        end
        ST_PUB: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // command decode from the current state
  always_comb begin
    cmd           = '0;
    cmd.capture   = in_fire;
    cmd.sec       = bqeq_pkg::SEC_MAX_W'(i_cnt);
    cmd.ch        = ch;
    cmd.tap       = step;
    cmd.hist_slot = bqeq_pkg::HSLOT_X1;
    unique case (state)
      ST_COEF: cmd.coef_wr = 1'b1;
      ST_PASS: begin
        cmd.mac_issue = (step <= bqeq_pkg::TAP_A2);
        priority if (step == STEP_WR_X2) begin
          cmd.hist_wr   = 1'b1;
          cmd.hist_slot = bqeq_pkg::HSLOT_X2;
        end else if (step == STEP_WR_X1) begin
          cmd.hist_wr   = 1'b1;
          cmd.hist_slot = bqeq_pkg::HSLOT_X1;
        end else if (step == STEP_WR_Y2) begin
          cmd.hist_wr   = 1'b1;
          cmd.hist_slot = bqeq_pkg::HSLOT_Y2;
        end else if (step == STEP_LAST) begin
          cmd.hist_wr   = 1'b1;
          cmd.hist_slot = bqeq_pkg::HSLOT_Y1;
        end else begin
          cmd.hist_wr = 1'b0;
        end
      end
      ST_GMUL: cmd.gain_mul = 1'b1;
      ST_GRND: cmd.gain_rnd = 1'b1;
      ST_MSAT: cmd.mono_sat = 1'b1;
      ST_PUB:  cmd.publish  = out_free;
      default: ;
    endcase
  end

  `BQEQ_ASSERT_SAME(a_no_overwrite, cmd.publish, out_free, "result overwritten before taken")
  `BQEQ_ASSERT_NEXT(a_result_held, (state == ST_PUB) && out_valid && !out_ready,
                    (state == ST_PUB) && out_valid, "pending result lost")
  `BQEQ_ASSERT_NEXT(a_pass_advance, (state == ST_PASS) && pass_done,
                    (state == ST_SCAN) && (i_cnt == SEC_CNT_W'($past(i_cnt) + 1'b1)),
                    "section walk did not advance after pass")

endmodule

FILE: src/bqeq_datapath.sv
// datapath: coefficient and history memories, shared multiply-accumulate, gain and saturation
module bqeq_datapath #(
  parameter int NUM_SECTIONS = bqeq_pkg::DEFAULT_NUM_SECTIONS
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  bqeq_pkg::cmd_t                             cmd,
  input  bqeq_pkg::cfg_t                             cfg,
  input  logic signed [bqeq_pkg::SAMPLE_W-1:0]       left_sample,
  input  logic signed [bqeq_pkg::SAMPLE_W-1:0]       right_sample,
  input  logic                                       last_in_buffer,
  input  logic        [bqeq_pkg::COEF_SEC_W-1:0]     coef_section,
  input  logic        [bqeq_pkg::COEF_SEL_W-1:0]     coef_select,
  input  logic signed [bqeq_pkg::COEF_W-1:0]         coef_value,
  output logic signed [bqeq_pkg::SAMPLE_W-1:0]       left_out,
  output logic signed [bqeq_pkg::SAMPLE_W-1:0]       right_out,
  output logic                                       last_out
);

  localparam int SEC_W      = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
  localparam int COEF_DEPTH = NUM_SECTIONS * bqeq_pkg::TAPS;
  localparam int HIST_DEPTH = NUM_SECTIONS * bqeq_pkg::HIST_PER_SEC;
  localparam int CA_W       = $clog2(COEF_DEPTH);
  localparam int HA_W       = $clog2(HIST_DEPTH);
  localparam int DW         = bqeq_pkg::DATA_W;
  localparam int SW         = bqeq_pkg::SAMPLE_W;
  localparam int WW         = bqeq_pkg::WIDE_W;

  function automatic logic signed [DW-1:0] sat_wide_to_data(input logic signed [WW-1:0] v);
    logic fits;
    fits = (&v[WW-1:DW-1]) || !(|v[WW-1:DW-1]);
    if (fits) begin
      return v[DW-1:0];
    end
    return v[WW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
  endfunction

  function automatic logic signed [SW-1:0] sat_wide_to_sample(input logic signed [WW-1:0] v);
    logic fits;
    fits = (&v[WW-1:SW-1]) || !(|v[WW-1:SW-1]);
    if (fits) begin
      return v[SW-1:0];
    end
    return v[WW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
  endfunction

  function automatic logic signed [SW-1:0] sat_data_to_sample(input logic signed [DW-1:0] v);
    logic fits;
    fits = (&v[DW-1:SW-1]) || !(|v[DW-1:SW-1]);
    if (fits) begin
      return v[SW-1:0];
    end
    return v[DW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
  endfunction

  // captured item
  logic signed [DW-1:0]                    l_val;
  logic signed [DW-1:0]                    r_val;
  logic                                    last_reg;
  logic [bqeq_pkg::COEF_SEC_W-1:0]         coef_sec_r;
  logic [bqeq_pkg::COEF_SEL_W-1:0]         coef_sel_r;
  logic signed [bqeq_pkg::COEF_W-1:0]      coef_val_r;

  // memories with per-entry valid bits, unwritten entries read as zero
  logic signed [bqeq_pkg::COEF_W-1:0] coef_mem [COEF_DEPTH];
  logic [COEF_DEPTH-1:0]              coef_vld;
  logic signed [DW-1:0]               hist_mem [HIST_DEPTH];
  logic [HIST_DEPTH-1:0]              hist_vld;

  logic [SEC_W-1:0]     sec;
  logic [CA_W-1:0]      coef_raddr;
  logic [CA_W-1:0]      coef_waddr;
  logic                 coef_we;
  bqeq_pkg::hist_slot_t rslot;
  logic [HA_W-1:0]      hist_raddr;
  logic [HA_W-1:0]      hist_waddr;
  logic signed [DW-1:0] hist_wdata;
  logic signed [DW-1:0] x_now;

  // mac pipeline
  logic                                coef_rd_v;
  logic signed [bqeq_pkg::COEF_W-1:0]  coef_rd;
  logic signed [DW-1:0]                hist_rd;
  logic                                first1;
  logic                                neg1;
  logic                                op_is_x1;
  logic                                ch1;
  logic signed [DW-1:0]                operand;
  logic                                prod_v;
  logic signed [bqeq_pkg::PROD_W-1:0]  prod;
  logic                                first2;
  logic                                neg2;
  logic signed [bqeq_pkg::ACC_W-1:0]   prod_ext;
  logic signed [bqeq_pkg::ACC_W-1:0]   acc;
  logic signed [bqeq_pkg::ACC_W-1:0]   acc_rnd;
  logic signed [DW-1:0]                y_rnd;

  // gain path
  logic signed [DW-1:0]                 gsel;
  logic signed [bqeq_pkg::GPROD_W-1:0]  gprod;
  logic signed [bqeq_pkg::GPROD_W-1:0]  gprod_rnd;
  logic signed [SW-1:0]                 res_l;
  logic signed [SW-1:0]                 res_r;

  assign sec        = cmd.sec[SEC_W-1:0];
  assign coef_raddr = CA_W'(32'(sec) * bqeq_pkg::TAPS + 32'(cmd.tap));
  assign coef_waddr = CA_W'(32'(coef_sec_r) * bqeq_pkg::TAPS + 32'(coef_sel_r));
  assign coef_we    = cmd.coef_wr && (32'(coef_sec_r) < NUM_SECTIONS)
                      && (32'(coef_sel_r) < bqeq_pkg::TAPS);
  assign rslot      = bqeq_pkg::hist_slot_t'(2'(cmd.tap - 3'd1));
  assign hist_raddr = HA_W'(32'(sec) * bqeq_pkg::HIST_PER_SEC
                      + 32'(cmd.ch) * bqeq_pkg::HIST_PER_CH + 32'(rslot));
  assign hist_waddr = HA_W'(32'(sec) * bqeq_pkg::HIST_PER_SEC
                      + 32'(cmd.ch) * bqeq_pkg::HIST_PER_CH + 32'(cmd.hist_slot));
  assign x_now      = cmd.ch ? r_val : l_val;

  // round half up, floor shift by 23, saturate to 32 bits
  assign acc_rnd = acc + bqeq_pkg::ACC_W'(1 << 22);
  assign y_rnd   = sat_wide_to_data(acc_rnd[bqeq_pkg::ACC_W-1:23]);

  always_comb begin
    unique case (cmd.hist_slot)
      bqeq_pkg::HSLOT_X1: hist_wdata = x_now;
      bqeq_pkg::HSLOT_Y1: hist_wdata = y_rnd;
      default:            hist_wdata = hist_rd;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_vld <= '0;
      hist_vld <= '0;
    end else begin
      if (coef_we) begin
        coef_vld[coef_waddr] <= 1'b1;
      end
      if (cmd.hist_wr) begin
        hist_vld[hist_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= coef_val_r;
    end
    if (cmd.mac_issue) begin
      coef_rd <= coef_vld[coef_raddr] ? coef_mem[coef_raddr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hist_wr) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    if (cmd.mac_issue) begin
      hist_rd <= hist_vld[hist_raddr] ? hist_mem[hist_raddr] : '0;
    end
  end

  // item capture and running channel values
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      l_val      <= DW'(left_sample);
      r_val      <= DW'(right_sample);
      last_reg   <= last_in_buffer;
      coef_sec_r <= coef_section;
      coef_sel_r <= coef_select;
      coef_val_r <= coef_value;
    end else if (cmd.hist_wr && (cmd.hist_slot == bqeq_pkg::HSLOT_Y1)) begin
      if (cmd.ch) begin
        r_val <= y_rnd;
      end else begin
        l_val <= y_rnd;
      end
    end
  end

  // mac control pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_rd_v <= 1'b0;
      prod_v    <= 1'b0;
    end else begin
      coef_rd_v <= cmd.mac_issue;
      prod_v    <= coef_rd_v;
    end
  end

  assign operand  = op_is_x1 ? (ch1 ? r_val : l_val) : hist_rd;
  assign prod_ext = bqeq_pkg::ACC_W'(prod);

  always_ff @(posedge clk) begin
    first1   <= (cmd.tap == bqeq_pkg::TAP_B0);
    op_is_x1 <= (cmd.tap == bqeq_pkg::TAP_B0);
    neg1     <= (cmd.tap >= bqeq_pkg::TAP_A1);
    ch1      <= cmd.ch;
    prod     <= coef_rd * operand;
    first2   <= first1;
    neg2     <= neg1;
    if (prod_v) begin
      acc <= (first2 ? '0 : acc) + (neg2 ? -prod_ext : prod_ext);
    end
  end

  // stereo gain, mono saturation and output register
  assign gsel      = cmd.ch ? r_val : l_val;
  assign gprod_rnd = gprod + bqeq_pkg::GPROD_W'(1 << 19);

  always_ff @(posedge clk) begin
    if (cmd.gain_mul) begin
      gprod <= gsel * $signed({1'b0, cfg.out_gain});
    end
    if (cmd.gain_rnd) begin
      if (cmd.ch) begin
        res_r <= sat_wide_to_sample(gprod_rnd[bqeq_pkg::GPROD_W-1:20]);
      end else begin
        res_l <= sat_wide_to_sample(gprod_rnd[bqeq_pkg::GPROD_W-1:20]);
      end
    end
    if (cmd.mono_sat) begin
      res_l <= sat_data_to_sample(l_val);
      res_r <= '0;
    end
    if (cmd.publish) begin
      left_out  <= res_l;
      right_out <= res_r;
      last_out  <= last_reg;
    end
  end

endmodule

FILE: src/biquad_cascade_equalizer.sv
// top level of the cascaded direct-form-I biquad equalizer
//
// mono or stereo equalizer built from up to NUM_SECTIONS biquad sections sharing one
// multiply-accumulate unit. an input transaction with func set loads one coefficient
// (b0, b1, b2, a1, a2 in signed q3.23) and returns nothing; it holds the block busy
// while the coefficient is written. a sample transaction walks the first active_sections
// sections and returns one result transaction. each enabled section gets one pass per
// channel (one in mono, two in stereo) on the shared multiplier, five taps issued one
// per cycle plus the read, multiply and accumulate stages; stereo results then get a
// gain multiply and round per channel, mono results one saturate step, before the
// result is published. in_ready is high only while no item is in flight; a finished
// result moves into the output register and the next item is taken right away, while
// the result after it is held back until the earlier one is claimed.
// coefficients and history are memories with per-entry valid bits cleared at reset,
// so no clearing pass is needed. configuration writes are taken every cycle and must
// only be issued while the block is idle
module biquad_cascade_equalizer #(
  parameter int NUM_SECTIONS = bqeq_pkg::DEFAULT_NUM_SECTIONS
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // input item channel
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    func,
  input  logic signed [bqeq_pkg::SAMPLE_W-1:0]    left_sample,
  input  logic signed [bqeq_pkg::SAMPLE_W-1:0]    right_sample,
  input  logic                                    last_in_buffer,
  input  logic        [bqeq_pkg::COEF_SEC_W-1:0]  coef_section,
  input  logic        [bqeq_pkg::COEF_SEL_W-1:0]  coef_select,
  input  logic signed [bqeq_pkg::COEF_W-1:0]      coef_value,
  // result channel
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [bqeq_pkg::SAMPLE_W-1:0]    left_out,
  output logic signed [bqeq_pkg::SAMPLE_W-1:0]    right_out,
  output logic                                    last_out,
  // configuration write channel
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic        [bqeq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic        [bqeq_pkg::CFG_DATA_W-1:0]  cfg_data
);

  bqeq_pkg::cfg_t cfg;
  bqeq_pkg::cmd_t cmd;

  // register bank: active sections, enable mask, skip, stereo, output gain
  bqeq_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer: section walk, per-pass step counter, result handshake
  bqeq_ctrl #(
    .NUM_SECTIONS (NUM_SECTIONS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg       (cfg),
    .cmd       (cmd)
  );

  // memories, shared multiply-accumulate, gain and output register
  bqeq_datapath #(
    .NUM_SECTIONS (NUM_SECTIONS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg            (cfg),
    .left_sample    (left_sample),
    .right_sample   (right_sample),
    .last_in_buffer (last_in_buffer),
    .coef_section   (coef_section),
    .coef_select    (coef_select),
    .coef_value     (coef_value),
    .left_out       (left_out),
    .right_out      (right_out),
    .last_out       (last_out)
  );

endmodule
